// ===== rtl/core/sbq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sbq_pkg: shared block pool byte queues, common types and constants
// Request and status codes, widths of the fixed fields, parameter defaults and
// the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package sbq_pkg;

    localparam int REQ_W  = 2;
    localparam int QID_W  = 3;
    localparam int DATA_W = 16;
    localparam int ST_W   = 2;
    localparam int BYTE_W = 8;

    localparam logic [BYTE_W-1:0] BYTE_MASK = 8'o377;

    localparam int NUM_BLOCKS_DEF  = 64;
    localparam int BLOCK_BYTES_DEF = 16;
    localparam int NUM_QUEUES_DEF  = 8;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUT_BYTE = 2'd0,
        REQ_GET_BYTE = 2'd1,
        REQ_PUT_WORD = 2'd2,
        REQ_GET_WORD = 2'd3
    } t_req;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_NOSPACE = 2'd2
    } t_status;

    typedef struct packed {
        logic    latch;
        logic    load;
        logic    pop_rd;
        logic    pop;
        logic    put;
        logic    get_rd;
        logic    get;
        logic    wb;
        logic    st_we;
        t_status st_code;
    } t_cmd;

    typedef struct packed {
        t_req req;
        logic phase;
        logic cnt_zero;
        logic cnt_lt2;
        logic need_blk;
        logic free_empty;
    } t_sts;

endpackage
`default_nettype wire

// ===== rtl/core/sbq_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sbq_datapath: queue records, free list, link and byte stores
// Holds the working copy of one queue record, the LIFO free list with its
// never-used watermark, the block link store and the byte store, and carries
// out the commands issued by the controller.
// ----------------------------------------------------------------------------
module sbq_datapath #(
    parameter int NUM_BLOCKS  = sbq_pkg::NUM_BLOCKS_DEF,
    parameter int BLOCK_BYTES = sbq_pkg::BLOCK_BYTES_DEF,
    parameter int NUM_QUEUES  = sbq_pkg::NUM_QUEUES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [sbq_pkg::REQ_W-1:0]     i_req_type,
    input  wire logic [sbq_pkg::QID_W-1:0]     i_queue_id,
    input  wire logic [sbq_pkg::DATA_W-1:0]    i_write_data,
    input  wire sbq_pkg::t_cmd                 i_cmd,
    output sbq_pkg::t_sts                      o_sts,
    output logic                               o_valid,
    output logic [sbq_pkg::DATA_W-1:0]         o_read_data,
    output logic [sbq_pkg::ST_W-1:0]           o_status
);
    import sbq_pkg::*;

    localparam int BW    = $clog2(NUM_BLOCKS);
    localparam int HW    = $clog2(BLOCK_BYTES);
    localparam int OW    = $clog2(BLOCK_BYTES + 1);
    localparam int QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int BYTES = NUM_BLOCKS * BLOCK_BYTES;
    localparam int AW    = $clog2(BYTES);
    localparam int CW    = $clog2(BYTES + 1);
    localparam int FW    = $clog2(NUM_BLOCKS + 1);

    typedef struct packed {
        logic [BW-1:0] hb;
        logic [HW-1:0] ho;
        logic [BW-1:0] tb;
        logic [OW-1:0] to;
        logic [CW-1:0] cnt;
    } t_qrec;

    t_qrec             m_qrec [NUM_QUEUES];
    logic [BW:0]       m_link [NUM_BLOCKS];
    logic [BYTE_W-1:0] m_bytes [BYTES];

    t_req              r_req;
    logic [QW-1:0]     r_q;
    logic [DATA_W-1:0] r_wd;
    logic              r_phase;
    t_status           r_st;
    logic [DATA_W-1:0] r_rd;
    t_qrec             r_qrd;
    logic              r_qvld;
    logic [NUM_QUEUES-1:0] r_qvalid;
    logic [BW-1:0]     r_hb;
    logic [HW-1:0]     r_ho;
    logic [BW-1:0]     r_tb;
    logic [OW-1:0]     r_to;
    logic [CW-1:0]     r_cnt;
    logic [BW-1:0]     r_fhead;
    logic              r_fempty;
    logic [FW-1:0]     r_fresh;
    logic [BW:0]       r_lrd;
    logic [BYTE_W-1:0] r_brd;
    logic              r_valid;
    logic [DATA_W-1:0] r_out_rd;
    t_status           r_out_st;

    logic [QID_W-1:0]  n_qred;
    logic [QW-1:0]     n_q;
    logic              n_fresh_hit;
    logic              n_pop_nv;
    logic [BW-1:0]     n_pop_nx;
    logic [AW-1:0]     n_waddr;
    logic [AW-1:0]     n_raddr;
    logic [HW:0]       n_ho;
    logic [CW-1:0]     n_cnt;
    logic              n_push;
    logic [BYTE_W-1:0] n_wbyte;
    logic              n_lwe;
    logic [BW-1:0]     n_laddr;
    logic [BW:0]       n_ldata;
    logic [BW-1:0]     n_lraddr;

    always_comb begin
        n_qred = i_queue_id;
        for (int i = 0; i < 8; i++) begin
            if (32'(n_qred) >= NUM_QUEUES) begin
                n_qred = n_qred - QID_W'(NUM_QUEUES);
            end
        end
        n_q = QW'(n_qred);
    end

    assign n_fresh_hit = FW'(r_fhead) < r_fresh;
    assign n_pop_nv    = n_fresh_hit ? (r_fhead != '0) : r_lrd[BW];
    assign n_pop_nx    = n_fresh_hit ? (r_fhead - BW'(1)) : r_lrd[BW-1:0];

    assign n_waddr = AW'(r_tb) * AW'(BLOCK_BYTES) + AW'(r_to);
    assign n_raddr = AW'(r_hb) * AW'(BLOCK_BYTES) + AW'(r_ho);
    assign n_ho    = (HW+1)'(r_ho) + (HW+1)'(1);
    assign n_cnt   = r_cnt - CW'(1);
    assign n_push  = i_cmd.get && ((n_cnt == '0) || (n_ho == (HW+1)'(BLOCK_BYTES)));
    assign n_wbyte = (r_phase ? r_wd[15:8] : r_wd[7:0]) & BYTE_MASK;
    assign n_lraddr = i_cmd.pop_rd ? r_fhead : r_hb;

    always_comb begin
        n_lwe   = 1'b0;
        n_laddr = r_hb;
        n_ldata = {!r_fempty, r_fhead};
        if (i_cmd.pop && (r_cnt != '0)) begin
            n_lwe   = 1'b1;
            n_laddr = r_tb;
            n_ldata = {1'b1, r_fhead};
        end else if (n_push) begin
            n_lwe   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_lwe) begin
            m_link[n_laddr] <= n_ldata;
        end
        if (i_cmd.pop_rd || i_cmd.get_rd) begin
            r_lrd <= m_link[n_lraddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.put) begin
            m_bytes[n_waddr] <= n_wbyte;
        end
        if (i_cmd.get_rd) begin
            r_brd <= m_bytes[n_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_qrd <= m_qrec[n_q];
        end
        if (i_cmd.wb) begin
            m_qrec[r_q] <= '{hb: r_hb, ho: r_ho, tb: r_tb, to: r_to, cnt: r_cnt};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qvalid <= '0;
            r_fhead  <= BW'(NUM_BLOCKS - 1);
            r_fempty <= 1'b0;
            r_fresh  <= FW'(NUM_BLOCKS);
            r_valid  <= 1'b0;
        end else begin
            r_valid <= i_cmd.wb;
            if (i_cmd.wb) begin
                r_qvalid[r_q] <= 1'b1;
            end
            if (i_cmd.pop) begin
                if (n_fresh_hit) begin
                    r_fresh <= FW'(r_fhead);
                end
                if (n_pop_nv) begin
                    r_fhead <= n_pop_nx;
                end else begin
                    r_fempty <= 1'b1;
                end
            end else if (n_push) begin
                r_fhead  <= r_hb;
                r_fempty <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req   <= t_req'(i_req_type);
            r_q     <= n_q;
            r_wd    <= i_write_data;
            r_phase <= 1'b0;
            r_st    <= ST_OK;
            r_rd    <= '0;
            r_qvld  <= r_qvalid[n_q];
        end
        if (i_cmd.st_we) begin
            r_st <= i_cmd.st_code;
        end
        if (i_cmd.load) begin
            if (r_qvld) begin
                r_hb  <= r_qrd.hb;
                r_ho  <= r_qrd.ho;
                r_tb  <= r_qrd.tb;
                r_to  <= r_qrd.to;
                r_cnt <= r_qrd.cnt;
            end else begin
                r_hb  <= '0;
                r_ho  <= '0;
                r_tb  <= '0;
                r_to  <= '0;
                r_cnt <= '0;
            end
        end else if (i_cmd.pop) begin
            if (r_cnt == '0) begin
                r_hb <= r_fhead;
                r_ho <= '0;
            end
            r_tb <= r_fhead;
            r_to <= '0;
        end else if (i_cmd.put) begin
            r_to    <= r_to + OW'(1);
            r_cnt   <= r_cnt + CW'(1);
            r_phase <= 1'b1;
        end else if (i_cmd.get) begin
            if (r_phase) begin
                r_rd[15:8] <= r_brd;
            end else begin
                r_rd[7:0] <= r_brd;
            end
            r_cnt   <= n_cnt;
            r_phase <= 1'b1;
            if (n_cnt == '0) begin
                r_hb <= '0;
                r_ho <= '0;
                r_tb <= '0;
                r_to <= '0;
            end else if (n_ho == (HW+1)'(BLOCK_BYTES)) begin
                r_hb <= r_lrd[BW-1:0];
                r_ho <= '0;
            end else begin
                r_ho <= n_ho[HW-1:0];
            end
        end
        if (i_cmd.wb) begin
            r_out_rd <= r_rd;
            r_out_st <= r_st;
        end
    end

    assign o_sts = '{
        req:        r_req,
        phase:      r_phase,
        cnt_zero:   (r_cnt == '0),
        cnt_lt2:    (r_cnt < CW'(2)),
        need_blk:   (r_cnt == '0) || (r_to == OW'(BLOCK_BYTES)),
        free_empty: r_fempty
    };

    assign o_valid     = r_valid;
    assign o_read_data = r_out_rd;
    assign o_status    = r_out_st;

endmodule
`default_nettype wire

// ===== rtl/core/sbq_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sbq_ctrl: request sequencer
// Steps one request through record fetch, checks, block allocation, byte
// moves and write-back, one byte at a time for word requests.
// ----------------------------------------------------------------------------
module sbq_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire sbq_pkg::t_sts i_sts,
    output sbq_pkg::t_cmd      o_cmd
);
    import sbq_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_QRD  = 9'b000000010,
        S_DEC  = 9'b000000100,
        S_PCHK = 9'b000001000,
        S_POP  = 9'b000010000,
        S_PUT  = 9'b000100000,
        S_GCHK = 9'b001000000,
        S_GRD  = 9'b010000000,
        S_WB   = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.st_code = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_QRD;
                end
            end
            S_QRD: begin
                o_cmd.load = 1'b1;
                n_state    = S_DEC;
            end
            S_DEC: begin
                case (i_sts.req)
                    REQ_PUT_BYTE: n_state = S_PCHK;
                    REQ_PUT_WORD: begin
                        if (i_sts.free_empty) begin
                            o_cmd.st_we   = 1'b1;
                            o_cmd.st_code = ST_NOSPACE;
                            n_state       = S_WB;
                        end else begin
                            n_state = S_PCHK;
                        end
                    end
                    REQ_GET_BYTE: begin
                        if (i_sts.cnt_zero) begin
                            o_cmd.st_we   = 1'b1;
                            o_cmd.st_code = ST_EMPTY;
                            n_state       = S_WB;
                        end else begin
                            n_state = S_GCHK;
                        end
                    end
                    default: begin
                        if (i_sts.cnt_lt2) begin
                            o_cmd.st_we   = 1'b1;
                            o_cmd.st_code = ST_EMPTY;
                            n_state       = S_WB;
                        end else begin
                            n_state = S_GCHK;
                        end
                    end
                endcase
            end
            S_PCHK: begin
                if (i_sts.need_blk) begin
                    if (i_sts.free_empty) begin
                        if (i_sts.req == REQ_PUT_BYTE) begin
                            o_cmd.st_we   = 1'b1;
                            o_cmd.st_code = ST_NOSPACE;
                        end
                        n_state = S_WB;
                    end else begin
                        o_cmd.pop_rd = 1'b1;
                        n_state      = S_POP;
                    end
                end else begin
                    n_state = S_PUT;
                end
            end
            S_POP: begin
                o_cmd.pop = 1'b1;
                n_state   = S_PUT;
            end
            S_PUT: begin
                o_cmd.put = 1'b1;
                if (i_sts.req == REQ_PUT_WORD && !i_sts.phase) begin
                    n_state = S_PCHK;
                end else begin
                    n_state = S_WB;
                end
            end
            S_GCHK: begin
                o_cmd.get_rd = 1'b1;
                n_state      = S_GRD;
            end
            S_GRD: begin
                o_cmd.get = 1'b1;
                if (i_sts.req == REQ_GET_WORD && !i_sts.phase) begin
                    n_state = S_GCHK;
                end else begin
                    n_state = S_WB;
                end
            end
            S_WB: begin
                o_cmd.wb = 1'b1;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule
`default_nettype wire

// ===== rtl/core/shared_block_pool_byte_queues_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// shared_block_pool_byte_queues_core: byte queues on a shared block pool
// Sequencing: a refused request goes from the checks straight to write-back (a
//   put byte with no free block is refused at the block check); a put byte
//   takes a block from the free list when one is needed; one byte per pass.
// Handshake: busy drops with the strobe cycle; start is taken only while busy is low.
// Reset: synchronous, all queues empty, free list full; the receiver cannot stall.
// ----------------------------------------------------------------------------
module shared_block_pool_byte_queues_core #(
    parameter int NUM_BLOCKS  = sbq_pkg::NUM_BLOCKS_DEF,
    parameter int BLOCK_BYTES = sbq_pkg::BLOCK_BYTES_DEF,
    parameter int NUM_QUEUES  = sbq_pkg::NUM_QUEUES_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [sbq_pkg::REQ_W-1:0]  i_req_type,
    input  wire logic [sbq_pkg::QID_W-1:0]  i_queue_id,
    input  wire logic [sbq_pkg::DATA_W-1:0] i_write_data,
    output logic                            o_valid,
    output logic [sbq_pkg::DATA_W-1:0]      o_read_data,
    output logic [sbq_pkg::ST_W-1:0]        o_status
);
    import sbq_pkg::*;

    t_cmd cmd;
    t_sts sts;

    sbq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    sbq_datapath #(
        .NUM_BLOCKS  (NUM_BLOCKS),
        .BLOCK_BYTES (BLOCK_BYTES),
        .NUM_QUEUES  (NUM_QUEUES)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_type   (i_req_type),
        .i_queue_id   (i_queue_id),
        .i_write_data (i_write_data),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_valid      (o_valid),
        .o_read_data  (o_read_data),
        .o_status     (o_status)
    );

    a_wb_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.wb |=> o_valid)
        else $error("write-back not followed by result strobe");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("transfer did not raise busy");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_read_data == '0))
        else $error("refused request returned data");

    a_pop_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.pop |-> !sts.free_empty)
        else $error("block taken from empty free list");

endmodule
`default_nettype wire
